>>> rtl/sgr_attribute_decoder_defines.svh
// ----------------------------------------------------------------------------
// SGR attribute decoder assertion macros
// Shared concurrent assertion helpers; they assume clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef SGR_ATTRIBUTE_DECODER_DEFINES_SVH
`define SGR_ATTRIBUTE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication: cond holds, so prop holds too
`define SGR_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("sgr assertion failed");

// Next-cycle implication: cond holds, so prop holds in the cycle after
`define SGR_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("sgr assertion failed");

`else

`define SGR_ASSERT_NOW(lbl, cond, prop)
`define SGR_ASSERT_NEXT(lbl, cond, prop)

`endif

`endif

>>> rtl/sgr_pkg.sv
// ----------------------------------------------------------------------------
// SGR decoder package
// Character codes, SGR code values, shared structs and the foreground palette.
// ----------------------------------------------------------------------------
package sgr_pkg;

    // Character codes
    localparam logic [7:0] CHAR_DIGIT_ZERO = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_NINE = 8'h39;
    localparam logic [7:0] CHAR_SEMICOLON  = 8'h3B;

    // SGR codes
    localparam logic [7:0] CODE_RESET     = 8'd0;
    localparam logic [7:0] CODE_BRIGHT    = 8'd1;
    localparam logic [7:0] CODE_UNDERLINE = 8'd4;
    localparam logic [7:0] CODE_BLINK     = 8'd5;
    localparam logic [7:0] CODE_INVERSE   = 8'd7;
    localparam logic [7:0] CODE_FG_FIRST  = 8'd30;
    localparam logic [7:0] CODE_FG_LAST   = 8'd37;
    localparam logic [7:0] CODE_BG_FIRST  = 8'd40;
    localparam logic [7:0] CODE_BG_LAST   = 8'd47;

    // Parameter saturation limit
    localparam logic [7:0] PARAM_MAX = 8'hFF;

    // Default colors
    localparam logic [2:0] FG_DEFAULT = 3'd7;
    localparam logic [2:0] BG_DEFAULT = 3'd0;

    typedef struct packed {
        logic       bright;
        logic       underline;
        logic       blink;
        logic       inverse;
        logic [2:0] fg;
        logic [2:0] bg;
    } attr_t;

    localparam attr_t ATTR_DEFAULT = '{
        bright:    1'b0,
        underline: 1'b0,
        blink:     1'b0,
        inverse:   1'b0,
        fg:        FG_DEFAULT,
        bg:        BG_DEFAULT
    };

    // Per-beat decode result handed from the character decoder to the
    // attribute unit and the parameter registers
    typedef struct packed {
        logic       apply;
        logic [7:0] code;
        logic [7:0] accum_next;
        logic       sep_next;
        logic       bad;
    } decode_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    // Bright and dark palettes, indexed by color
    localparam logic [23:0] PAL_BRIGHT [8] = '{
        24'h555555, 24'hFF5555, 24'h55FF55, 24'hFFFF55,
        24'h5555FF, 24'hFF55FF, 24'h55FFFF, 24'hFFFFFF
    };
    localparam logic [23:0] PAL_DARK [8] = '{
        24'h000000, 24'hAA0000, 24'h00AA00, 24'hAA5500,
        24'h0000AA, 24'hAA00AA, 24'h00AAAA, 24'hAAAAAA
    };

    function automatic rgb_t pal_lookup(input logic bright, input logic [2:0] idx);
        rgb_t rgb;
        rgb = bright ? rgb_t'(PAL_BRIGHT[idx]) : rgb_t'(PAL_DARK[idx]);
        return rgb;
    endfunction

endpackage

>>> rtl/sgr_char_decode.sv
// ----------------------------------------------------------------------------
// SGR character decoder
// Classifies one character, builds the saturating parameter and decides
// whether this beat applies a code.
// ----------------------------------------------------------------------------
module sgr_char_decode (
    input  logic            [7:0] symbol,
    input  logic                  has_char,
    input  logic                  last,
    input  logic            [7:0] accum,
    input  logic                  sep,
    output sgr_pkg::decode_t      dec
);

    logic        is_digit;
    logic        is_semi;
    logic [11:0] sum;
    logic [7:0]  accum_upd;
    logic        sep_upd;

    // Classify the character
    assign is_digit = has_char && (symbol >= sgr_pkg::CHAR_DIGIT_ZERO)
                      && (symbol <= sgr_pkg::CHAR_DIGIT_NINE);
    assign is_semi  = has_char && (symbol == sgr_pkg::CHAR_SEMICOLON);

    // Accumulate decimal digit, saturate at the limit
    assign sum = ({4'd0, accum} * 12'd10) + {8'd0, symbol[3:0]};

    always_comb
    begin
        accum_upd = accum;
        sep_upd   = sep;
        if (is_digit)
        begin
            accum_upd = (sum > {4'd0, sgr_pkg::PARAM_MAX}) ? sgr_pkg::PARAM_MAX : sum[7:0];
            sep_upd   = 1'b0;
        end
        else if (is_semi)
        begin
            sep_upd = 1'b1;
        end
    end

    // A semicolon applies the parameter; the list end applies it unless the
    // list closed on a semicolon. At most one apply per beat.
    always_comb
    begin
        dec.apply      = is_semi || (last && !sep_upd);
        dec.code       = accum_upd;
        dec.accum_next = (is_semi || last) ? 8'd0 : accum_upd;
        dec.sep_next   = last ? 1'b0 : sep_upd;
        dec.bad        = has_char && !is_digit && !is_semi;
    end

endmodule

>>> rtl/sgr_attr_unit.sv
// ----------------------------------------------------------------------------
// SGR attribute unit
// Holds the rendition attributes and applies at most one SGR code per beat.
// ----------------------------------------------------------------------------
module sgr_attr_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                apply,
    input  logic          [7:0] code,
    output sgr_pkg::attr_t      attr_next,
    output logic                unknown
);

    sgr_pkg::attr_t attr_reg;

    // Apply the code to the current attributes
    always_comb
    begin
        attr_next = attr_reg;
        unknown   = 1'b0;
        if (apply)
        begin
            if (code == sgr_pkg::CODE_RESET)
                attr_next = sgr_pkg::ATTR_DEFAULT;
            else if (code == sgr_pkg::CODE_BRIGHT)
                attr_next.bright = 1'b1;
            else if (code == sgr_pkg::CODE_UNDERLINE)
                attr_next.underline = 1'b1;
            else if (code == sgr_pkg::CODE_BLINK)
                attr_next.blink = 1'b1;
            else if (code == sgr_pkg::CODE_INVERSE)
                attr_next.inverse = 1'b1;
            else if ((code >= sgr_pkg::CODE_FG_FIRST) && (code <= sgr_pkg::CODE_FG_LAST))
                attr_next.fg = 3'(code - sgr_pkg::CODE_FG_FIRST);
            else if ((code >= sgr_pkg::CODE_BG_FIRST) && (code <= sgr_pkg::CODE_BG_LAST))
                attr_next.bg = 3'(code - sgr_pkg::CODE_BG_FIRST);
            else
                unknown = 1'b1;
        end
    end

    // Hold attributes; advance on each processed beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            attr_reg <= sgr_pkg::ATTR_DEFAULT;
        else if (advance)
            attr_reg <= attr_next;
    end

endmodule

>>> rtl/sgr_attribute_decoder.sv
// ----------------------------------------------------------------------------
// SGR attribute decoder, top level
// Decodes an ANSI SGR parameter list, one character per beat, into the
// current rendition attributes and foreground RGB color.
// ----------------------------------------------------------------------------
// Every input beat yields exactly one result beat. A beat is captured in an
// input register, decoded and applied to the attribute state on its way
// out, and lands in the output register; the block takes one beat per cycle
// while the output side does not stall. A result is valid once its beat has
// passed the input and output registers, limited only by the single
// decode-and-update stage between them. An output stall holds the output
// register and a full input register, so at most two beats are in flight.
// ----------------------------------------------------------------------------
`include "sgr_attribute_decoder_defines.svh"

module sgr_attribute_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       has_char,
    input  logic       last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       bright_on,
    output logic       underline_on,
    output logic       blink_on,
    output logic       inverse_on,
    output logic [2:0] fore_index,
    output logic [2:0] back_index,
    output logic [7:0] fore_red,
    output logic [7:0] fore_green,
    output logic [7:0] fore_blue,
    output logic       unknown_code,
    output logic       bad_char
);

    // Input register
    logic       in_valid_reg;
    logic [7:0] symbol_reg;
    logic       has_char_reg;
    logic       last_reg;

    // Parameter state
    logic [7:0] accum_reg;
    logic       sep_reg;

    // Output register
    logic           out_valid_reg;
    sgr_pkg::attr_t attr_out_reg;
    sgr_pkg::rgb_t  rgb_out_reg;
    logic           unknown_out_reg;
    logic           bad_out_reg;

    logic             advance;
    sgr_pkg::decode_t dec;
    sgr_pkg::attr_t   attr_next;
    logic             unknown;
    sgr_pkg::rgb_t    rgb_next;

    // Move a beat from the input register when the output register frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Capture the input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            symbol_reg   <= symbol;
            has_char_reg <= has_char;
            last_reg     <= last;
        end
    end

    sgr_char_decode u_char_decode (
        .symbol   (symbol_reg),
        .has_char (has_char_reg),
        .last     (last_reg),
        .accum    (accum_reg),
        .sep      (sep_reg),
        .dec      (dec)
    );

    sgr_attr_unit u_attr_unit (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .apply     (dec.apply),
        .code      (dec.code),
        .attr_next (attr_next),
        .unknown   (unknown)
    );

    // Advance the parameter accumulator and separator mark
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= 8'd0;
            sep_reg   <= 1'b0;
        end
        else if (advance)
        begin
            accum_reg <= dec.accum_next;
            sep_reg   <= dec.sep_next;
        end
    end

    // Look up the foreground color
    assign rgb_next = sgr_pkg::pal_lookup(attr_next.bright, attr_next.fg);

    // Output register: fill on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            attr_out_reg    <= attr_next;
            rgb_out_reg     <= rgb_next;
            unknown_out_reg <= unknown;
            bad_out_reg     <= dec.bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign bright_on    = attr_out_reg.bright;
    assign underline_on = attr_out_reg.underline;
    assign blink_on     = attr_out_reg.blink;
    assign inverse_on   = attr_out_reg.inverse;
    assign fore_index   = attr_out_reg.fg;
    assign back_index   = attr_out_reg.bg;
    assign fore_red     = rgb_out_reg.red;
    assign fore_green   = rgb_out_reg.green;
    assign fore_blue    = rgb_out_reg.blue;
    assign unknown_code = unknown_out_reg;
    assign bad_char     = bad_out_reg;

    // A closing semicolon always leaves an empty parameter behind it
    `SGR_ASSERT_NOW(a_sep_empty_accum, sep_reg, accum_reg == 8'd0)

    // An empty output register never blocks the input side
    `SGR_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, in_ready)

    // A new result appears only from a processed beat
    `SGR_ASSERT_NOW(a_out_from_advance, $rose(out_valid_reg), $past(advance))

    // A stalled input beat keeps its contents
    `SGR_ASSERT_NEXT(a_in_hold, in_valid_reg && !advance,
        in_valid_reg && $stable(symbol_reg) && $stable(has_char_reg) && $stable(last_reg))

endmodule

>>> dv/sgr_attribute_decoder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SGR attribute decoder checker
// Watches both channels of the decoder, predicts every result beat from the
// accepted input beats with a shadow copy of the attribute state, and compares
// each result field by field, in order.
// ----------------------------------------------------------------------------
module sgr_attribute_decoder_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       has_char,
    input  logic       last,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       bright_on,
    input  logic       underline_on,
    input  logic       blink_on,
    input  logic       inverse_on,
    input  logic [2:0] fore_index,
    input  logic [2:0] back_index,
    input  logic [7:0] fore_red,
    input  logic [7:0] fore_green,
    input  logic [7:0] fore_blue,
    input  logic       unknown_code,
    input  logic       bad_char,
    output int         mismatches,
    output int         pending_results,
    output int         beats_checked,
    output int         lists_closed,
    output int         unknown_seen,
    output int         bad_seen
);

    // Dark yellow is shown as brown: green at half strength
    localparam logic [2:0] BROWN_INDEX = 3'd3;
    localparam int         REPORT_LIMIT = 10;

    typedef struct packed {
        sgr_pkg::attr_t attr;
        logic [7:0]     red;
        logic [7:0]     green;
        logic [7:0]     blue;
        logic           unknown;
        logic           bad;
    } sgr_view_t;

    sgr_pkg::attr_t shadow_attr;
    logic [7:0]     param_value;
    logic           after_semicolon;
    sgr_view_t      expected_views[$];
    int             error_total;
    int             checked_total;
    int             list_total;
    int             unknown_total;
    int             bad_total;

    // Apply one SGR code to the shadow attributes; flag codes with no meaning
    function automatic logic apply_sgr_code(input logic [7:0] code);
        logic       unrecognized;
        logic [7:0] offset;
        unrecognized = 1'b0;
        if (code == sgr_pkg::CODE_RESET)
        begin
            shadow_attr = sgr_pkg::ATTR_DEFAULT;
        end
        else if (code == sgr_pkg::CODE_BRIGHT)
        begin
            shadow_attr.bright = 1'b1;
        end
        else if (code == sgr_pkg::CODE_UNDERLINE)
        begin
            shadow_attr.underline = 1'b1;
        end
        else if (code == sgr_pkg::CODE_BLINK)
        begin
            shadow_attr.blink = 1'b1;
        end
        else if (code == sgr_pkg::CODE_INVERSE)
        begin
            shadow_attr.inverse = 1'b1;
        end
        else if (code >= sgr_pkg::CODE_FG_FIRST && code <= sgr_pkg::CODE_FG_LAST)
        begin
            offset = code - sgr_pkg::CODE_FG_FIRST;
            shadow_attr.fg = offset[2:0];
        end
        else if (code >= sgr_pkg::CODE_BG_FIRST && code <= sgr_pkg::CODE_BG_LAST)
        begin
            offset = code - sgr_pkg::CODE_BG_FIRST;
            shadow_attr.bg = offset[2:0];
        end
        else
        begin
            unrecognized = 1'b1;
        end
        return unrecognized;
    endfunction

    // Advance the shadow decoder by one character beat and build its result
    function automatic sgr_view_t decode_sgr_beat(input logic [7:0] sym, input logic has,
                                                  input logic ends);
        sgr_view_t   view;
        int unsigned grown;
        logic [2:0]  idx;
        view = '0;
        if (has)
        begin
            if (sym >= sgr_pkg::CHAR_DIGIT_ZERO && sym <= sgr_pkg::CHAR_DIGIT_NINE)
            begin
                grown = param_value * 10 + (sym - sgr_pkg::CHAR_DIGIT_ZERO);
                param_value = (grown > sgr_pkg::PARAM_MAX) ? sgr_pkg::PARAM_MAX : grown[7:0];
                after_semicolon = 1'b0;
            end
            else if (sym == sgr_pkg::CHAR_SEMICOLON)
            begin
                view.unknown = apply_sgr_code(param_value);
                param_value = '0;
                after_semicolon = 1'b1;
            end
            else
            begin
                view.bad = 1'b1;
            end
        end

        // Close the list: a trailing semicolon already applied its parameter
        if (ends)
        begin
            if (!after_semicolon)
            begin
                view.unknown = view.unknown | apply_sgr_code(param_value);
            end
            param_value = '0;
            after_semicolon = 1'b0;
        end

        // Look up the foreground color: red, green, blue follow index bits 0, 1, 2
        view.attr = shadow_attr;
        idx = shadow_attr.fg;
        if (shadow_attr.bright)
        begin
            view.red   = idx[0] ? 8'hFF : 8'h55;
            view.green = idx[1] ? 8'hFF : 8'h55;
            view.blue  = idx[2] ? 8'hFF : 8'h55;
        end
        else
        begin
            view.red   = idx[0] ? 8'hAA : 8'h00;
            view.green = idx[1] ? 8'hAA : 8'h00;
            view.blue  = idx[2] ? 8'hAA : 8'h00;
            if (idx == BROWN_INDEX)
            begin
                view.green = 8'h55;
            end
        end
        return view;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            error_total++;
            if (error_total <= REPORT_LIMIT)
            begin
                $display("[%0t] result beat %0d, %s: expected 0x%0h, got 0x%0h",
                         $realtime, checked_total, name, want, got);
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        sgr_view_t seen;
        sgr_view_t want;
        if (!rst_n)
        begin
            shadow_attr = sgr_pkg::ATTR_DEFAULT;
            param_value = '0;
            after_semicolon = 1'b0;
            expected_views.delete();
            error_total = 0;
            checked_total = 0;
            list_total = 0;
            unknown_total = 0;
            bad_total = 0;
        end
        else
        begin
            // Predict the result of each accepted input beat
            if (in_valid && in_ready)
            begin
                expected_views.push_back(decode_sgr_beat(symbol, has_char, last));
                if (last)
                begin
                    list_total++;
                end
            end

            // Compare each accepted result beat with the oldest prediction
            if (out_valid && out_ready)
            begin
                seen.attr.bright    = bright_on;
                seen.attr.underline = underline_on;
                seen.attr.blink     = blink_on;
                seen.attr.inverse   = inverse_on;
                seen.attr.fg        = fore_index;
                seen.attr.bg        = back_index;
                seen.red            = fore_red;
                seen.green          = fore_green;
                seen.blue           = fore_blue;
                seen.unknown        = unknown_code;
                seen.bad            = bad_char;
                if (expected_views.size() == 0)
                begin
                    error_total++;
                    if (error_total <= REPORT_LIMIT)
                    begin
                        $display("[%0t] result beat with no input beat waiting: %p",
                                 $realtime, seen);
                    end
                end
                else
                begin
                    want = expected_views.pop_front();
                    check_field("bright_on", want.attr.bright, seen.attr.bright);
                    check_field("underline_on", want.attr.underline, seen.attr.underline);
                    check_field("blink_on", want.attr.blink, seen.attr.blink);
                    check_field("inverse_on", want.attr.inverse, seen.attr.inverse);
                    check_field("fore_index", want.attr.fg, seen.attr.fg);
                    check_field("back_index", want.attr.bg, seen.attr.bg);
                    check_field("fore_red", want.red, seen.red);
                    check_field("fore_green", want.green, seen.green);
                    check_field("fore_blue", want.blue, seen.blue);
                    check_field("unknown_code", want.unknown, seen.unknown);
                    check_field("bad_char", want.bad, seen.bad);
                    checked_total++;
                    if (want.unknown)
                    begin
                        unknown_total++;
                    end
                    if (want.bad)
                    begin
                        bad_total++;
                    end
                end
            end
        end

        // Publish counts; readers at the next edge see this edge's totals
        mismatches      <= error_total;
        pending_results <= expected_views.size();
        beats_checked   <= checked_total;
        lists_closed    <= list_total;
        unknown_seen    <= unknown_total;
        bad_seen        <= bad_total;
    end

endmodule

>>> dv/sgr_attribute_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SGR attribute decoder testbench
// Feeds SGR parameter lists, stray characters and empty lists into the
// decoder under three idling mixes, holds the output off once to fill the
// block, and lets the checker compare every result beat.
// ----------------------------------------------------------------------------
module sgr_attribute_decoder_tb;

    localparam int BEAT_TARGET     = 750;
    localparam int PHASE_BEATS     = 250;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 4;
    localparam int RESET_CYCLES    = 10;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] symbol    = 8'h00;
    logic       has_char  = 1'b0;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       bright_on;
    logic       underline_on;
    logic       blink_on;
    logic       inverse_on;
    logic [2:0] fore_index;
    logic [2:0] back_index;
    logic [7:0] fore_red;
    logic [7:0] fore_green;
    logic [7:0] fore_blue;
    logic       unknown_code;
    logic       bad_char;

    int mismatches;
    int pending_results;
    int beats_checked;
    int lists_closed;
    int unknown_seen;
    int bad_seen;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off_req  = 1'b0;
    int counted_beats = 0;

    sgr_attribute_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .symbol       (symbol),
        .has_char     (has_char),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .bright_on    (bright_on),
        .underline_on (underline_on),
        .blink_on     (blink_on),
        .inverse_on   (inverse_on),
        .fore_index   (fore_index),
        .back_index   (back_index),
        .fore_red     (fore_red),
        .fore_green   (fore_green),
        .fore_blue    (fore_blue),
        .unknown_code (unknown_code),
        .bad_char     (bad_char)
    );

    sgr_attribute_decoder_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .symbol          (symbol),
        .has_char        (has_char),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .bright_on       (bright_on),
        .underline_on    (underline_on),
        .blink_on        (blink_on),
        .inverse_on      (inverse_on),
        .fore_index      (fore_index),
        .back_index      (back_index),
        .fore_red        (fore_red),
        .fore_green      (fore_green),
        .fore_blue       (fore_blue),
        .unknown_code    (unknown_code),
        .bad_char        (bad_char),
        .mismatches      (mismatches),
        .pending_results (pending_results),
        .beats_checked   (beats_checked),
        .lists_closed    (lists_closed),
        .unknown_seen    (unknown_seen),
        .bad_seen        (bad_seen)
    );

    always #1 clk = ~clk;

    // Offer one character beat after a random idle gap and hold it until taken
    task automatic send_beat(input logic [7:0] sym, input logic has, input logic ends);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= sym;
        has_char <= has;
        last     <= ends;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        counted_beats++;
    endtask

    // Send a whole parameter list; an empty text goes as the lone no-character beat
    task automatic send_list(input string text);
        if (text.len() == 0)
        begin
            send_beat(8'($urandom_range(255)), 1'b0, 1'b1);
        end
        else
        begin
            for (int i = 0; i < text.len(); i++)
            begin
                if ($urandom_range(29) == 0)
                begin
                    send_beat(8'($urandom_range(255)), 1'b0, 1'b0);
                end
                send_beat(text[i], 1'b1, i == text.len() - 1);
            end
        end
    endtask

    // Drop valid and wait until every result beat has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Drive ready: random stalls, or one long hold-off on request
    initial
    begin : receiver
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
                @(posedge clk);
            end
        end
    end

    // End the run when no beat has moved on either channel for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("No beat moved for %0d cycles, giving up", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        string       list_text;
        int          n_params;
        int          pick;
        int          phase;
        logic [7:0]  code;
        logic [7:0]  stray;

        phase = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 24;
        recv_idle_pct = 86;

        // Empty list resets; every flag code; color extremes
        send_list("");
        send_list("1;4;5;7");
        send_list("37;40");
        // Stray top byte, then a no-character beat in mid-list
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(sgr_pkg::CHAR_DIGIT_ZERO + 8'd5, 1'b0, 1'b0);
        // Saturated parameter applied by a semicolon that also ends the list
        send_list("999;");
        // Stray zero byte ends a list, so the pending parameter still applies
        send_beat(sgr_pkg::CHAR_DIGIT_ZERO + 8'd3, 1'b1, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
        // Lone semicolon applies an empty parameter; then an explicit reset
        send_list(";");
        send_list("0");

        while (counted_beats < BEAT_TARGET)
        begin
            // Step through the idling mixes, draining between them
            if (phase == 0 && counted_beats >= PHASE_BEATS)
            begin
                drain_results();
                send_idle_pct = 86;
                recv_idle_pct = 24;
                phase = 1;
            end
            else if (phase == 1 && counted_beats >= 2 * PHASE_BEATS)
            begin
                drain_results();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_off_req = 1'b1;
                phase = 2;
            end

            if ($urandom_range(9) == 0)
            begin
                // Noise: any byte with any flags
                send_beat(8'($urandom_range(255)), 1'($urandom_range(1)),
                          1'($urandom_range(1)));
            end
            else
            begin
                // Build a list of one to four parameters
                list_text = "";
                n_params = $urandom_range(1, 4);
                for (int p = 0; p < n_params; p++)
                begin
                    if (p > 0)
                    begin
                        list_text = $sformatf("%s%c", list_text, sgr_pkg::CHAR_SEMICOLON);
                    end
                    if ($urandom_range(9) == 0)
                    begin
                        list_text = $sformatf("%s%c", list_text, sgr_pkg::CHAR_DIGIT_ZERO);
                    end
                    pick = $urandom_range(99);
                    if (pick < 60)
                    begin
                        pick = $urandom_range(20);
                        case (pick)
                            0:       code = sgr_pkg::CODE_RESET;
                            1:       code = sgr_pkg::CODE_BRIGHT;
                            2:       code = sgr_pkg::CODE_UNDERLINE;
                            3:       code = sgr_pkg::CODE_BLINK;
                            4:       code = sgr_pkg::CODE_INVERSE;
                            default: code = (pick < 13)
                                          ? sgr_pkg::CODE_FG_FIRST + 8'(pick - 5)
                                          : sgr_pkg::CODE_BG_FIRST + 8'(pick - 13);
                        endcase
                        list_text = $sformatf("%s%0d", list_text, code);
                    end
                    else if (pick < 85)
                    begin
                        list_text = $sformatf("%s%0d", list_text, $urandom_range(255));
                    end
                    else if (pick < 95)
                    begin
                        list_text = $sformatf("%s%0d", list_text,
                                              $urandom_range(256, 99999));
                    end
                    if ($urandom_range(19) == 0)
                    begin
                        stray = 8'($urandom_range(1, 255));
                        while ((stray >= sgr_pkg::CHAR_DIGIT_ZERO &&
                                stray <= sgr_pkg::CHAR_DIGIT_NINE) ||
                               stray == sgr_pkg::CHAR_SEMICOLON)
                        begin
                            stray = 8'($urandom_range(1, 255));
                        end
                        list_text = $sformatf("%s%c", list_text, stray);
                    end
                end
                if ($urandom_range(6) == 0)
                begin
                    list_text = $sformatf("%s%c", list_text, sgr_pkg::CHAR_SEMICOLON);
                end
                send_list(list_text);
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d result beats over %0d closed lists;",
                 beats_checked, lists_closed);
        $display("%0d unknown codes, %0d stray chars, sender-heavy and receiver-heavy idling,",
                 unknown_seen, bad_seen);
        $display("full rate and one long output hold-off.");
        if (mismatches == 0 && pending_results == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/sgr_pkg.sv
rtl/sgr_char_decode.sv
rtl/sgr_attr_unit.sv
rtl/sgr_attribute_decoder.sv
dv/sgr_attribute_decoder_checker.sv
dv/sgr_attribute_decoder_tb.sv
